[rtl/ole_pkg.sv]
// Package for the ordered list engine: sizes, command and status codes,
// controller states and the control word shared by the row of list cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ole_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int IDX_W      = $clog2(LIST_DEPTH);
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int WORD_W     = 32;
	localparam int KIND_W     = 3;
	localparam int POS_W      = 5;
	localparam int STAT_W     = 2;
	localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REVERSE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DUMP    = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DUMP
	} state_t;

	typedef enum logic [1:0] {
		SH_HOLD,
		SH_UP,
		SH_DOWN
	} shift_t;

	typedef struct packed {
		shift_t             act;
		logic [IDX_W-1:0]   lo;
		logic [IDX_W-1:0]   hi;
		logic [WORD_W-1:0]  bus;
	} cell_ctl_t;

endpackage

`default_nettype wire

[rtl/ole_cell.sv]
// One list cell: holds one word and takes its neighbor's word, the broadcast
// word or keeps its own, as the shared control word says.
// Depends on ole_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ole_cell import ole_pkg::*; (
	input  wire logic              clk,
	input  wire logic [IDX_W-1:0]  idx,
	input  wire cell_ctl_t         ctl,
	input  wire logic [WORD_W-1:0] left,
	input  wire logic [WORD_W-1:0] right,
	output logic [WORD_W-1:0]      word
);

	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] word_d;

	always_comb begin
		word_d = word_q;
		case (ctl.act)
			SH_UP: begin
				if (idx == ctl.lo) begin
					word_d = ctl.bus;
				end else if (idx > ctl.lo) begin
					word_d = left;
				end
			end
			SH_DOWN: begin
				if (idx == ctl.hi) begin
					word_d = ctl.bus;
				end else if (idx >= ctl.lo && idx < ctl.hi) begin
					word_d = right;
				end
			end
			default: begin
				word_d = word_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word = word_q;

endmodule

`default_nettype wire

[rtl/ole_chain.sv]
// Row of list cells, each linked to both neighbors, with one read port that
// picks the word at a chosen cell.
// Depends on ole_pkg and ole_cell.
`timescale 1ns / 1ps
`default_nettype none

module ole_chain import ole_pkg::*; (
	input  wire logic              clk,
	input  wire cell_ctl_t         ctl,
	input  wire logic [IDX_W-1:0]  rd_idx,
	output logic [WORD_W-1:0]      rd_data
);

	logic [WORD_W-1:0] words [LIST_DEPTH];

	for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = words[g-1];
		end

		if (g == LIST_DEPTH - 1) begin : g_final
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = words[g+1];
		end

		ole_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(g)),
			.ctl   (ctl),
			.left  (left_w),
			.right (right_w),
			.word  (words[g])
		);
	end

	assign rd_data = words[rd_idx];

endmodule

`default_nettype wire

[rtl/ordered_list_engine.sv]
// Ordered list engine: bounded list of signed words edited by commands.
// Depends on ole_pkg and ole_chain.
//
// Usage:
// The slave stream takes one command word at a time: tuser holds the kind
// (clear, insert, delete, reverse, dump) and tdata holds position and value.
// The master stream returns result words of value, status and element count;
// tlast marks the final result of each command. Every command but dump gives
// one result; dump gives one result per element, or one empty-status result.
// The list is kept in a row of cells in physical order plus an order flag;
// insert and delete shift the cells above the edit point, and reverse only
// toggles the flag.
// A command is captured into the command registers; its result is loaded
// into the output register from the execute state once that is free. A
// non-empty dump yields one element per cycle from the dump state unless the
// receiver stalls, as the cells rotate once around the list.
// A command is taken only while the engine is idle, but it can be taken while
// the previous result still waits in the output register.
// When the receiver stalls, the engine holds its result and waits; no result
// is lost. Reset empties the list and clears the order flag; cell contents
// are not cleared and are never read before they are written.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_engine import ole_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // position[4:0], value[36:5], zero fill
	input  wire logic [2:0]  s_tuser,  // kind[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // value_res[31:0], status[33:32], count[38:34]
	output logic             m_tlast
);

	state_t              state_q, state_d;
	logic [KIND_W-1:0]   kind_q;
	logic [POS_W-1:0]    pos_q;
	logic [WORD_W-1:0]   value_q;
	logic [CNT_W-1:0]    count_q, count_d;
	logic                flip_q, flip_d;
	logic [IDX_W-1:0]    dcnt_q, dcnt_d;

	logic                out_valid_q;
	logic [WORD_W-1:0]   out_value_q, out_value_d;
	logic [STAT_W-1:0]   out_status_q, out_status_d;
	logic [CNT_W-1:0]    out_count_q;
	logic                out_last_q, out_last_d;
	logic                out_load;
	logic                out_free;

	cell_ctl_t           ctl;
	logic [IDX_W-1:0]    rd_idx;
	logic [WORD_W-1:0]   rd_data;

	logic [CMP_W-1:0]    cnt_x, pos_x;
	logic                ins_bad, ins_full, del_bad, dump_end;
	logic [IDX_W-1:0]    ins_k, del_k, tail_idx;

	assign out_free = !out_valid_q || m_tready;
	assign cnt_x    = CMP_W'(count_q);
	assign pos_x    = CMP_W'(pos_q);
	assign ins_bad  = pos_x > cnt_x;
	assign ins_full = count_q == CNT_W'(LIST_DEPTH);
	assign del_bad  = (pos_x == '0) || (pos_x > cnt_x);
	assign ins_k    = flip_q ? IDX_W'(cnt_x - pos_x) : IDX_W'(pos_x);
	assign del_k    = flip_q ? IDX_W'(cnt_x - pos_x) : IDX_W'(pos_x - CMP_W'(1));
	assign tail_idx = IDX_W'(count_q - CNT_W'(1));
	assign dump_end = (CNT_W'(dcnt_q) + CNT_W'(1)) == count_q;

	ole_chain u_chain (
		.clk     (clk),
		.ctl     (ctl),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					if (kind_q == KIND_DUMP && count_q != '0) begin
						state_d = S_DUMP;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_DUMP: begin
				if (out_free && dump_end) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		out_load     = 1'b0;
		out_value_d  = '0;
		out_status_d = STAT_OK;
		out_last_d   = 1'b1;
		count_d      = count_q;
		flip_d       = flip_q;
		dcnt_d       = dcnt_q;
		rd_idx       = '0;
		ctl.act      = SH_HOLD;
		ctl.lo       = '0;
		ctl.hi       = '0;
		ctl.bus      = rd_data;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				dcnt_d   = '0;
			end
			S_EXEC: begin
				rd_idx = del_k;
				if (out_free) begin
					case (kind_q)
						KIND_CLEAR: begin
							out_load = 1'b1;
							count_d  = '0;
							flip_d   = 1'b0;
						end
						KIND_INSERT: begin
							out_load = 1'b1;
							if (ins_bad) begin
								out_status_d = STAT_BADPOS;
							end else if (ins_full) begin
								out_status_d = STAT_FULL;
							end else begin
								ctl.act = SH_UP;
								ctl.lo  = ins_k;
								ctl.bus = value_q;
								count_d = count_q + CNT_W'(1);
							end
						end
						KIND_DELETE: begin
							out_load = 1'b1;
							if (del_bad) begin
								out_status_d = STAT_BADPOS;
							end else begin
								out_value_d = rd_data;
								ctl.act     = SH_DOWN;
								ctl.lo      = del_k;
								ctl.hi      = IDX_W'(LIST_DEPTH - 1);
								count_d     = count_q - CNT_W'(1);
							end
						end
						KIND_REVERSE: begin
							out_load = 1'b1;
							flip_d   = !flip_q;
						end
						KIND_DUMP: begin
							if (count_q == '0) begin
								out_load     = 1'b1;
								out_status_d = STAT_EMPTY;
							end
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			S_DUMP: begin
				rd_idx = flip_q ? tail_idx : '0;
				if (out_free) begin
					out_load    = 1'b1;
					out_value_d = rd_data;
					out_last_d  = dump_end;
					dcnt_d      = dcnt_q + IDX_W'(1);
					if (flip_q) begin
						ctl.act = SH_UP;
						ctl.lo  = '0;
					end else begin
						ctl.act = SH_DOWN;
						ctl.lo  = '0;
						ctl.hi  = tail_idx;
					end
				end
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			flip_q      <= 1'b0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			flip_q  <= flip_d;
			dcnt_q  <= dcnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q  <= s_tuser;
			pos_q   <= s_tdata[4:0];
			value_q <= s_tdata[36:5];
		end
		if (out_load) begin
			out_value_q  <= out_value_d;
			out_status_q <= out_status_d;
			out_count_q  <= count_d;
			out_last_q   <= out_last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, POS_W'(out_count_q), out_status_q, out_value_q};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

[rtl/ole_checker.sv]
// Port-level checker for the ordered list engine, bound to the top level.
// Depends on ordered_list_engine's port list only.
`timescale 1ns / 1ps
`default_nettype none

module ole_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic        m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("Stalled result word changed.");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Command word accepted while the previous one was in progress.");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[38:34] <= 5'd16)
		else $error("Reported count exceeds list depth.");

	a_empty_dump: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] == 2'd3 |->
			m_tlast && m_tdata[38:34] == 5'd0 && m_tdata[31:0] == 32'd0)
		else $error("Empty status word is malformed.");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[33:32] == 2'd1 || m_tdata[33:32] == 2'd2) |->
			m_tlast && m_tdata[31:0] == 32'd0)
		else $error("Rejected command word carries data or is not final.");

endmodule

bind ordered_list_engine ole_checker u_ole_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
